FILE: hw/rtl/iexu_pkg.sv
// ----------------------------------------------------------------------------
// iexu_pkg
// Shared types and constants for the integer execute unit: operation codes,
// memory access sizes, the input and result transaction layouts.
// ----------------------------------------------------------------------------
package iexu_pkg;

    typedef enum logic [5:0] {
        OP_LB          = 6'd0,
        OP_LH          = 6'd1,
        OP_LW          = 6'd2,
        OP_LBU         = 6'd3,
        OP_LHU         = 6'd4,
        OP_SB          = 6'd5,
        OP_SH          = 6'd6,
        OP_SW          = 6'd7,
        OP_ADD         = 6'd8,
        OP_SUB         = 6'd9,
        OP_SLL         = 6'd10,
        OP_SLT         = 6'd11,
        OP_SLTU        = 6'd12,
        OP_XOR         = 6'd13,
        OP_SRL         = 6'd14,
        OP_SRA         = 6'd15,
        OP_OR          = 6'd16,
        OP_AND         = 6'd17,
        OP_ADDI        = 6'd18,
        OP_SLTI        = 6'd19,
        OP_SLTIU       = 6'd20,
        OP_XORI        = 6'd21,
        OP_ORI         = 6'd22,
        OP_ANDI        = 6'd23,
        OP_SLLI        = 6'd24,
        OP_SRLI        = 6'd25,
        OP_SRAI        = 6'd26,
        OP_LUI         = 6'd27,
        OP_AUIPC       = 6'd28,
        OP_BEQ         = 6'd29,
        OP_BNE         = 6'd30,
        OP_BLT         = 6'd31,
        OP_BGE         = 6'd32,
        OP_BLTU        = 6'd33,
        OP_BGEU        = 6'd34,
        OP_JAL         = 6'd35,
        OP_JALR        = 6'd36,
        OP_ECALL       = 6'd37,
        OP_LOAD_RETURN = 6'd38
    } op_t;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    localparam logic [31:0] PC_STEP = 32'd4;

    typedef struct packed {
        logic [5:0]         operation;
        logic [3:0]         dest_reg;
        logic [3:0]         src_reg_a;
        logic [3:0]         src_reg_b;
        logic signed [31:0] immediate;
        logic [31:0]        load_data;
    } in_item_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        mem_valid;
        logic        mem_write;
        logic [31:0] mem_addr;
        logic [1:0]  mem_size;
        logic [31:0] mem_wdata;
        logic        wb_valid;
        logic [3:0]  wb_index;
        logic [31:0] wb_value;
        logic        halted;
    } out_item_t;

    // load in flight, filled in by a load request and used by load_return
    typedef struct packed {
        logic [3:0] dest;
        logic [1:0] size;
        logic       sgn;
    } pend_t;

endpackage

FILE: hw/rtl/rv32e_execute_unit.sv
// ----------------------------------------------------------------------------
// rv32e_execute_unit
// Integer execute unit for decoded RV32E instructions with a 16-entry
// register file, PC, load/store request generation and ECALL halt.
// ----------------------------------------------------------------------------
// Stages: register file read at input accept, then execute into the output register.
// Throughput: 1 transaction per cycle unless the output stalls; regfile read at accept,
//   written at execute; a same-cycle write-to-read bypass covers back-to-back.
// Reset: PC 0, halt and pending load cleared, register file valid bits cleared
//   at once (entries read 0 until written); no clearing pass.
module rv32e_execute_unit
    import iexu_pkg::*;
#(
    parameter int NUM_REGS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data
);

    localparam int IDX_W = $clog2(NUM_REGS);

    logic        accept;
    logic        ex_adv;
    logic        ex_vld_reg;
    logic        ex_vld_next;
    in_item_t    ex_item_reg;
    logic        out_vld_reg;
    logic        out_vld_next;
    out_item_t   out_data_reg;
    logic [31:0] pc_reg;
    logic        halt_reg;
    pend_t       pend_reg;

    logic [31:0]      src_a;
    logic [31:0]      src_b;
    out_item_t        res;
    logic             halt_next;
    pend_t            pend_next;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;

    assign ex_adv   = ex_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = ex_vld_reg && !ex_adv;
    assign accept   = in_valid && !in_stall;

    assign wr_en   = ex_adv && res.wb_valid;
    assign wr_addr = IDX_W'(res.wb_index);

    iexu_regfile #(
        .NUM_REGS (NUM_REGS)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr_a (IDX_W'(in_data.src_reg_a)),
        .rd_addr_b (IDX_W'(in_data.src_reg_b)),
        .rd_data_a (src_a),
        .rd_data_b (src_b),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (res.wb_value)
    );

    iexu_exec #(
        .NUM_REGS (NUM_REGS)
    ) u_exec (
        .item      (ex_item_reg),
        .src_a     (src_a),
        .src_b     (src_b),
        .pc        (pc_reg),
        .halt      (halt_reg),
        .pend      (pend_reg),
        .res       (res),
        .halt_next (halt_next),
        .pend_next (pend_next)
    );

    always_comb
    begin
        ex_vld_next = ex_vld_reg;
        if (accept)
        begin
            ex_vld_next = 1'b1;
        end
        else if (ex_adv)
        begin
            ex_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (ex_adv)
        begin
            out_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            pc_reg      <= '0;
            halt_reg    <= 1'b0;
            pend_reg    <= '0;
        end
        else
        begin
            ex_vld_reg  <= ex_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg_wr_en)
            begin
                pc_reg <= cfg_wr_data;
            end
            else if (ex_adv)
            begin
                pc_reg <= res.next_pc;
            end
            if (ex_adv)
            begin
                halt_reg <= halt_next;
                pend_reg <= pend_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ex_item_reg <= in_data;
        end
        if (ex_adv)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    // halt is sticky until reset
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halt flag cleared without reset");

    a_halt_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |-> !wr_en)
        else $error("register file written while halted");

    a_halt_pc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg && !cfg_wr_en |=> $stable(pc_reg))
        else $error("PC moved while halted");

    a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> wr_addr != '0)
        else $error("write to x0");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_stall |-> !ex_adv)
        else $error("execute advanced into a full output register");

endmodule

FILE: hw/rtl/iexu_regfile.sv
// ----------------------------------------------------------------------------
// iexu_regfile
// Register file memory: one write port, two registered read ports with
// write-to-read bypass. Per-entry valid bits make unwritten entries read 0.
// ----------------------------------------------------------------------------
module iexu_regfile
    import iexu_pkg::*;
#(
    parameter int NUM_REGS = 16,
    parameter int IDX_W    = $clog2(NUM_REGS)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr_a,
    input  logic [IDX_W-1:0] rd_addr_b,
    output logic [31:0]      rd_data_a,
    output logic [31:0]      rd_data_b,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [31:0]      wr_data
);

    logic [31:0] mem_reg [NUM_REGS];
    logic        vld_reg [NUM_REGS];
    logic [31:0] rd_data_a_reg;
    logic [31:0] rd_data_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // a write in the same cycle wins over the stored entry
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && wr_addr == rd_addr_a)
            begin
                rd_data_a_reg <= wr_data;
            end
            else if (vld_reg[rd_addr_a])
            begin
                rd_data_a_reg <= mem_reg[rd_addr_a];
            end
            else
            begin
                rd_data_a_reg <= '0;
            end

            if (wr_en && wr_addr == rd_addr_b)
            begin
                rd_data_b_reg <= wr_data;
            end
            else if (vld_reg[rd_addr_b])
            begin
                rd_data_b_reg <= mem_reg[rd_addr_b];
            end
            else
            begin
                rd_data_b_reg <= '0;
            end
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

FILE: hw/rtl/iexu_exec.sv
// ----------------------------------------------------------------------------
// iexu_exec
// Execute logic: ALU, branch and jump resolution, memory request forming,
// load return extension, and the next halt and pending-load state.
// ----------------------------------------------------------------------------
module iexu_exec
    import iexu_pkg::*;
#(
    parameter int NUM_REGS = 16
)
(
    input  in_item_t    item,
    input  logic [31:0] src_a,
    input  logic [31:0] src_b,
    input  logic [31:0] pc,
    input  logic        halt,
    input  pend_t       pend,
    output out_item_t   res,
    output logic        halt_next,
    output pend_t       pend_next
);

    logic [31:0] imm;
    logic [31:0] pc_inc;
    logic [31:0] pc_tgt;
    logic [31:0] ea;
    logic        lt_ab;
    logic        ltu_ab;
    logic        lt_ai;
    logic        ltu_ai;
    logic        wr;
    logic [3:0]  wr_idx;
    logic [31:0] wv;
    logic        take;
    logic [31:0] npc;

    assign imm    = item.immediate;
    assign pc_inc = pc + PC_STEP;
    assign pc_tgt = pc + imm;
    assign ea     = src_a + imm;
    assign lt_ab  = $signed(src_a) < $signed(src_b);
    assign ltu_ab = src_a < src_b;
    assign lt_ai  = $signed(src_a) < $signed(imm);
    assign ltu_ai = src_a < imm;

    always_comb
    begin
        res       = '0;
        pend_next = pend;
        halt_next = halt;
        wr        = 1'b0;
        wr_idx    = item.dest_reg;
        wv        = '0;
        take      = 1'b0;
        npc       = pc_inc;

        if (halt)
        begin
            npc = pc;
        end
        else
        begin
            unique case (item.operation)
                OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU:
                begin
                    res.mem_valid = 1'b1;
                    res.mem_addr  = ea;
                    if (item.operation == OP_LB || item.operation == OP_LBU)
                    begin
                        res.mem_size = SIZE_BYTE;
                    end
                    else if (item.operation == OP_LW)
                    begin
                        res.mem_size = SIZE_WORD;
                    end
                    else
                    begin
                        res.mem_size = SIZE_HALF;
                    end
                    pend_next.dest = item.dest_reg;
                    pend_next.size = res.mem_size;
                    pend_next.sgn  = item.operation == OP_LB || item.operation == OP_LH
                                     || item.operation == OP_LW;
                end
                OP_SB:
                begin
                    res.mem_valid = 1'b1;
                    res.mem_write = 1'b1;
                    res.mem_addr  = ea;
                    res.mem_size  = SIZE_BYTE;
                    res.mem_wdata = {24'd0, src_b[7:0]};
                end
                OP_SH:
                begin
                    res.mem_valid = 1'b1;
                    res.mem_write = 1'b1;
                    res.mem_addr  = ea;
                    res.mem_size  = SIZE_HALF;
                    res.mem_wdata = {16'd0, src_b[15:0]};
                end
                OP_SW:
                begin
                    res.mem_valid = 1'b1;
                    res.mem_write = 1'b1;
                    res.mem_addr  = ea;
                    res.mem_size  = SIZE_WORD;
                    res.mem_wdata = src_b;
                end
                OP_LOAD_RETURN:
                begin
                    npc    = pc;
                    wr     = 1'b1;
                    wr_idx = pend.dest;
                    if (pend.size == SIZE_BYTE)
                    begin
                        wv = {{24{pend.sgn & item.load_data[7]}}, item.load_data[7:0]};
                    end
                    else if (pend.size == SIZE_HALF)
                    begin
                        wv = {{16{pend.sgn & item.load_data[15]}}, item.load_data[15:0]};
                    end
                    else
                    begin
                        wv = item.load_data;
                    end
                end
                OP_ECALL:
                begin
                    halt_next = 1'b1;
                end
                OP_ADD:   begin wr = 1'b1; wv = src_a + src_b; end
                OP_SUB:   begin wr = 1'b1; wv = src_a - src_b; end
                OP_SLL:   begin wr = 1'b1; wv = src_a << src_b[4:0]; end
                OP_SLT:   begin wr = 1'b1; wv = {31'd0, lt_ab}; end
                OP_SLTU:  begin wr = 1'b1; wv = {31'd0, ltu_ab}; end
                OP_XOR:   begin wr = 1'b1; wv = src_a ^ src_b; end
                OP_SRL:   begin wr = 1'b1; wv = src_a >> src_b[4:0]; end
                OP_SRA:   begin wr = 1'b1; wv = 32'($signed(src_a) >>> src_b[4:0]); end
                OP_OR:    begin wr = 1'b1; wv = src_a | src_b; end
                OP_AND:   begin wr = 1'b1; wv = src_a & src_b; end
                OP_ADDI:  begin wr = 1'b1; wv = ea; end
                OP_SLTI:  begin wr = 1'b1; wv = {31'd0, lt_ai}; end
                OP_SLTIU: begin wr = 1'b1; wv = {31'd0, ltu_ai}; end
                OP_XORI:  begin wr = 1'b1; wv = src_a ^ imm; end
                OP_ORI:   begin wr = 1'b1; wv = src_a | imm; end
                OP_ANDI:  begin wr = 1'b1; wv = src_a & imm; end
                OP_SLLI:  begin wr = 1'b1; wv = src_a << imm[4:0]; end
                OP_SRLI:  begin wr = 1'b1; wv = src_a >> imm[4:0]; end
                OP_SRAI:  begin wr = 1'b1; wv = 32'($signed(src_a) >>> imm[4:0]); end
                OP_LUI:   begin wr = 1'b1; wv = imm; end
                OP_AUIPC: begin wr = 1'b1; wv = pc_tgt; end
                OP_JAL:
                begin
                    wr  = 1'b1;
                    wv  = pc_inc;
                    npc = pc_tgt;
                end
                OP_JALR:
                begin
                    wr  = 1'b1;
                    wv  = pc_inc;
                    npc = {ea[31:1], 1'b0};
                end
                OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU:
                begin
                    unique case (item.operation)
                        OP_BEQ:  take = src_a == src_b;
                        OP_BNE:  take = src_a != src_b;
                        OP_BLT:  take = lt_ab;
                        OP_BGE:  take = !lt_ab;
                        OP_BLTU: take = ltu_ab;
                        default: take = !ltu_ab;
                    endcase
                    if (take)
                    begin
                        npc = pc_tgt;
                    end
                end
                default:
                begin
                    // undefined opcode: no effect at all
                    npc = pc;
                end
            endcase
        end

        if (wr_idx == 4'd0 || int'(wr_idx) >= NUM_REGS)
        begin
            wr = 1'b0;
        end

        res.next_pc  = npc;
        res.wb_valid = wr;
        res.wb_index = wr ? wr_idx : 4'd0;
        res.wb_value = wr ? wv : 32'd0;
        res.halted   = halt_next;
    end

endmodule

FILE: verif/rv32e_execute_unit_tb.sv
// ----------------------------------------------------------------------------
// rv32e_execute_unit_tb
// Self-checking bench for the RV32E integer execute unit. A behavioral copy of
// the register file, PC, pending load and halt state predicts every result
// transaction, and a scoreboard compares the DUT output against it field by
// field. Directed cases, weighted random instruction streams under several
// start_pc settings and idle patterns, a long output hold-off, and a final
// ECALL halt are exercised.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rv32e_execute_unit_tb;
    import iexu_pkg::*;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          HOLD_CYCLES  = 120;
    localparam int          DRAIN_CYCLES = 4;
    localparam int          MAX_GAP      = 40;
    localparam logic [5:0]  OP_UNUSED_LO = 6'(OP_LOAD_RETURN + 1);
    localparam logic [5:0]  OP_UNUSED_HI = 6'd63;

    localparam logic [3:0] X0 = 4'd0, X1 = 4'd1, X2 = 4'd2, X3 = 4'd3, X4 = 4'd4;
    localparam logic [3:0] X5 = 4'd5, X6 = 4'd6, X7 = 4'd7, X8 = 4'd8, X9 = 4'd9;
    localparam logic [3:0] X10 = 4'd10, X11 = 4'd11, X12 = 4'd12, X13 = 4'd13;
    localparam logic [3:0] X14 = 4'd14, X15 = 4'd15;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    in_item_t    in_data     = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    out_item_t   out_data;

    // model state
    logic [31:0] gpr [16];
    logic [31:0] prog_ctr;
    pend_t       load_pend;
    logic        halt_seen;

    out_item_t   exp_results [$];
    int          fail_count     = 0;
    int          cycle_count    = 0;
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    bit          hold_req       = 1'b0;

    rv32e_execute_unit #(
        .NUM_REGS (16)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL rv32e_execute_unit");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Instruction predictor
    // ------------------------------------------------------------------
    function automatic out_item_t predict_exec(input in_item_t it);
        out_item_t   r;
        logic [31:0] a, b, imm, ld, npc, wv;
        logic [3:0]  rd;
        logic        wr, take;
        r    = '0;
        a    = gpr[it.src_reg_a];
        b    = gpr[it.src_reg_b];
        imm  = it.immediate;
        ld   = it.load_data;
        rd   = it.dest_reg;
        npc  = prog_ctr + PC_STEP;
        wv   = '0;
        take = 1'b0;
        wr   = (it.operation >= OP_ADD && it.operation <= OP_JALR) &&
               !(it.operation >= OP_BEQ && it.operation <= OP_BGEU);
        if (halt_seen)
        begin
            npc = prog_ctr;
            wr  = 1'b0;
        end
        else
        begin
            case (it.operation)
                OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU:
                begin
                    r.mem_valid = 1'b1;
                    r.mem_addr  = a + imm;
                    if (it.operation == OP_LB || it.operation == OP_LBU)
                        r.mem_size = SIZE_BYTE;
                    else if (it.operation == OP_LW)
                        r.mem_size = SIZE_WORD;
                    else
                        r.mem_size = SIZE_HALF;
                    load_pend.dest = rd;
                    load_pend.size = r.mem_size;
                    load_pend.sgn  = (it.operation == OP_LB || it.operation == OP_LH ||
                                      it.operation == OP_LW);
                end
                OP_SB, OP_SH, OP_SW:
                begin
                    r.mem_valid = 1'b1;
                    r.mem_write = 1'b1;
                    r.mem_addr  = a + imm;
                    if (it.operation == OP_SB)
                    begin
                        r.mem_size  = SIZE_BYTE;
                        r.mem_wdata = {24'd0, b[7:0]};
                    end
                    else if (it.operation == OP_SH)
                    begin
                        r.mem_size  = SIZE_HALF;
                        r.mem_wdata = {16'd0, b[15:0]};
                    end
                    else
                    begin
                        r.mem_size  = SIZE_WORD;
                        r.mem_wdata = b;
                    end
                end
                OP_LOAD_RETURN:
                begin
                    npc = prog_ctr;
                    rd  = load_pend.dest;
                    wr  = 1'b1;
                    if (load_pend.size == SIZE_BYTE)
                        wv = {{24{load_pend.sgn & ld[7]}}, ld[7:0]};
                    else if (load_pend.size == SIZE_HALF)
                        wv = {{16{load_pend.sgn & ld[15]}}, ld[15:0]};
                    else
                        wv = ld;
                end
                OP_ECALL:   halt_seen = 1'b1;
                OP_ADD:     wv = a + b;
                OP_SUB:     wv = a - b;
                OP_SLL:     wv = a << b[4:0];
                OP_SLT:     wv = {31'd0, $signed(a) < $signed(b)};
                OP_SLTU:    wv = {31'd0, a < b};
                OP_XOR:     wv = a ^ b;
                OP_SRL:     wv = a >> b[4:0];
                OP_SRA:     wv = $signed(a) >>> b[4:0];
                OP_OR:      wv = a | b;
                OP_AND:     wv = a & b;
                OP_ADDI:    wv = a + imm;
                OP_SLTI:    wv = {31'd0, $signed(a) < $signed(imm)};
                OP_SLTIU:   wv = {31'd0, a < imm};
                OP_XORI:    wv = a ^ imm;
                OP_ORI:     wv = a | imm;
                OP_ANDI:    wv = a & imm;
                OP_SLLI:    wv = a << imm[4:0];
                OP_SRLI:    wv = a >> imm[4:0];
                OP_SRAI:    wv = $signed(a) >>> imm[4:0];
                OP_LUI:     wv = imm;
                OP_AUIPC:   wv = prog_ctr + imm;
                OP_JAL:
                begin
                    wv  = prog_ctr + PC_STEP;
                    npc = prog_ctr + imm;
                end
                OP_JALR:
                begin
                    wv  = prog_ctr + PC_STEP;
                    npc = (a + imm) & ~32'd1;
                end
                OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU:
                begin
                    case (it.operation)
                        OP_BEQ:  take = (a == b);
                        OP_BNE:  take = (a != b);
                        OP_BLT:  take = ($signed(a) < $signed(b));
                        OP_BGE:  take = !($signed(a) < $signed(b));
                        OP_BLTU: take = (a < b);
                        default: take = (a >= b);
                    endcase
                    if (take)
                        npc = prog_ctr + imm;
                end
                default:    npc = prog_ctr;  // unused opcode, no effect
            endcase
        end
        if (wr && rd == X0)
            wr = 1'b0;
        if (wr)
            gpr[rd] = wv;
        prog_ctr    = npc;
        r.next_pc   = npc;
        r.wb_valid  = wr;
        r.wb_index  = wr ? rd : X0;
        r.wb_value  = wr ? wv : '0;
        r.halted    = halt_seen;
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s mismatch: expected %h, actual %h", fname, want_v, got_v);
            fail_count++;
        end
    endtask

    // Scoreboard: sample both handshakes at the rising edge.
    always @(posedge clk)
    begin : scoreboard
        out_item_t want;
        if (rst_n)
        begin
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (exp_results.size() == 0)
                begin
                    $error("result transaction with nothing outstanding");
                    fail_count++;
                end
                else
                begin
                    want = exp_results.pop_front();
                    check_field("next_pc",   want.next_pc,   out_data.next_pc);
                    check_field("mem_valid", 32'(want.mem_valid), 32'(out_data.mem_valid));
                    check_field("mem_write", 32'(want.mem_write), 32'(out_data.mem_write));
                    check_field("mem_addr",  want.mem_addr,  out_data.mem_addr);
                    check_field("mem_size",  32'(want.mem_size),  32'(out_data.mem_size));
                    check_field("mem_wdata", want.mem_wdata, out_data.mem_wdata);
                    check_field("wb_valid",  32'(want.wb_valid),  32'(out_data.wb_valid));
                    check_field("wb_index",  32'(want.wb_index),  32'(out_data.wb_index));
                    check_field("wb_value",  want.wb_value,  out_data.wb_value);
                    check_field("halted",    32'(want.halted),    32'(out_data.halted));
                end
            end
            if (cfg_wr_en)
                prog_ctr = cfg_wr_data;
            if (in_valid && in_stall === 1'b0)
                exp_results.push_back(predict_exec(in_data));
        end
    end

    // Output side stall generator; a hold-off request freezes it high.
    initial
    begin : sink_stall_gen
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
                out_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic in_item_t mk_instr(input logic [5:0] op, input logic [3:0] rd,
                                          input logic [3:0] ra, input logic [3:0] rb,
                                          input logic [31:0] imm, input logic [31:0] ld);
        in_item_t it;
        it.operation = op;
        it.dest_reg  = rd;
        it.src_reg_a = ra;
        it.src_reg_b = rb;
        it.immediate = imm;
        it.load_data = ld;
        return it;
    endfunction

    task automatic send_instr(input in_item_t it);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < src_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
    endtask

    // Sender pause: drop valid and wait for every outstanding result.
    task automatic settle_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (exp_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_start_pc(input logic [31:0] v);
        settle_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [31:0] pick_imm();
        int sel;
        sel = $urandom_range(99);
        if (sel < 30)
            return $urandom();
        else if (sel < 60)
            return $urandom_range(4095) - 2048;
        else if (sel < 75)
            return $urandom_range(63);
        else
        begin
            case ($urandom_range(4))
                0:       return 32'h0000_0000;
                1:       return 32'hFFFF_FFFF;
                2:       return 32'h7FFF_FFFF;
                3:       return 32'h8000_0000;
                default: return 32'h0000_0001;
            endcase
        end
    endfunction

    function automatic logic [31:0] pick_data();
        if ($urandom_range(1))
            return $urandom();
        case ($urandom_range(5))
            0:       return 32'h0000_0080;
            1:       return 32'h0000_8000;
            2:       return 32'h0000_007F;
            3:       return 32'hFFFF_7FFF;
            4:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
        endcase
    endfunction

    function automatic logic [3:0] rand_reg();
        return 4'($urandom_range(15));
    endfunction

    // Weighted random instruction stream; ignored opcodes do not count.
    task automatic run_random_stream(input int n_items);
        int         sent, sel;
        logic [5:0] op;
        sent = 0;
        while (sent < n_items)
        begin
            sel = $urandom_range(99);
            if (sel < 22)
            begin
                op = 6'($urandom_range(OP_LHU, OP_LB));
                send_instr(mk_instr(op, rand_reg(), rand_reg(), rand_reg(), pick_imm(),
                                    $urandom()));
                sent++;
                // mostly a matching return, sometimes broken by another op
                if ($urandom_range(99) < 15)
                begin
                    op = 6'($urandom_range(OP_JALR, OP_LB));
                    send_instr(mk_instr(op, rand_reg(), rand_reg(), rand_reg(),
                                        pick_imm(), $urandom()));
                    sent++;
                end
                send_instr(mk_instr(OP_LOAD_RETURN, rand_reg(), rand_reg(), rand_reg(),
                                    $urandom(), pick_data()));
                sent++;
            end
            else if (sel < 26)
            begin
                send_instr(mk_instr(OP_LOAD_RETURN, rand_reg(), rand_reg(), rand_reg(),
                                    $urandom(), pick_data()));
                sent++;
            end
            else if (sel < 30)
            begin
                op = 6'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
                send_instr(mk_instr(op, rand_reg(), rand_reg(), rand_reg(), $urandom(),
                                    $urandom()));
            end
            else if (sel < 40)
            begin
                op = 6'($urandom_range(OP_SW, OP_SB));
                send_instr(mk_instr(op, rand_reg(), rand_reg(), rand_reg(), pick_imm(),
                                    $urandom()));
                sent++;
            end
            else
            begin
                op = 6'($urandom_range(OP_JALR, OP_ADD));
                send_instr(mk_instr(op, rand_reg(), rand_reg(), rand_reg(), pick_imm(),
                                    $urandom()));
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset defaults: PC 0, zero registers, load return with nothing pending.
    task automatic test_reset_state();
        send_instr(mk_instr(OP_LOAD_RETURN, X5, X0, X0, '0, 32'hFFFF_FFFF));
        send_instr(mk_instr(OP_ADD, X1, X7, X9, '0, '0));
    endtask

    task automatic test_directed();
        write_start_pc(32'hFFFF_FFF8);
        send_instr(mk_instr(OP_LUI,   X1,  X0,  X0, 32'h8000_0000, '0));
        send_instr(mk_instr(OP_ADDI,  X2,  X0,  X0, 32'hFFFF_FFFF, '0));
        send_instr(mk_instr(OP_ADDI,  X3,  X0,  X0, 32'h7FFF_FFFF, '0));
        send_instr(mk_instr(OP_ADDI,  X4,  X0,  X0, 32'd33, '0));
        send_instr(mk_instr(OP_ADD,   X5,  X3,  X1, '0, '0));
        send_instr(mk_instr(OP_SUB,   X6,  X1,  X3, '0, '0));
        // shift by register holding 33: only the low five bits count
        send_instr(mk_instr(OP_SLL,   X7,  X2,  X4, '0, '0));
        send_instr(mk_instr(OP_SRL,   X8,  X1,  X4, '0, '0));
        send_instr(mk_instr(OP_SRA,   X9,  X1,  X4, '0, '0));
        send_instr(mk_instr(OP_SLT,   X10, X1,  X3, '0, '0));
        send_instr(mk_instr(OP_SLTU,  X11, X1,  X3, '0, '0));
        send_instr(mk_instr(OP_SLTIU, X12, X3,  X0, 32'hFFFF_FFFF, '0));
        send_instr(mk_instr(OP_SRAI,  X13, X1,  X0, 32'd63, '0));
        send_instr(mk_instr(OP_ADD,   X0,  X2,  X2, '0, '0));
        send_instr(mk_instr(OP_AUIPC, X14, X0,  X0, 32'h7FFF_F000, '0));
        send_instr(mk_instr(OP_BLTU,  X0,  X3,  X2, 32'hFFFF_FFF8, '0));
        send_instr(mk_instr(OP_BGE,   X0,  X1,  X3, 32'h0000_0100, '0));
        send_instr(mk_instr(OP_JAL,   X15, X0,  X0, 32'h8000_0000, '0));
        send_instr(mk_instr(OP_JALR,  X15, X2,  X0, '0, '0));
        send_instr(mk_instr(OP_SH,    X0,  X0,  X2, 32'hFFFF_FFFF, '0));
        send_instr(mk_instr(OP_SW,    X0,  X3,  X1, 32'd1, '0));
        send_instr(mk_instr(OP_LB,    X5,  X0,  X0, 32'h8000_0000, '0));
        send_instr(mk_instr(OP_LOAD_RETURN, X0, X0, X0, '0, 32'h1234_5680));
        send_instr(mk_instr(OP_LHU,   X6,  X2,  X0, 32'd1, '0));
        send_instr(mk_instr(OP_LOAD_RETURN, X0, X0, X0, '0, 32'hFFFF_8001));
        send_instr(mk_instr(OP_UNUSED_HI, X7, X2, X2, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    endtask

    task automatic test_random_traffic(input logic [31:0] pc0, input int n_items,
                                       input int src_pct, input int sink_pct);
        write_start_pc(pc0);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        run_random_stream(n_items);
    endtask

    // Long output hold-off while the sender keeps offering, then a full pause and a stream under random output stalls.
    task automatic test_backpressure();
        write_start_pc(32'h8000_0000);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_req       = 1'b1;
        run_random_stream(60);
        settle_idle();
        sink_stall_pct = 50;
        run_random_stream(40);
    endtask

    // ECALL halts for good: everything after it is ignored.
    task automatic test_halt();
        write_start_pc(32'h0000_1000);
        src_idle_pct   = 20;
        sink_stall_pct = 40;
        send_instr(mk_instr(OP_LW,    X3, X0, X0, 32'h40, '0));
        send_instr(mk_instr(OP_ECALL, X0, X0, X0, '0, '0));
        send_instr(mk_instr(OP_ADDI,  X4, X2, X0, 32'd5, '0));
        send_instr(mk_instr(OP_LOAD_RETURN, X0, X0, X0, '0, 32'hDEAD_BEEF));
        send_instr(mk_instr(OP_SW,    X0, X2, X3, 32'd8, '0));
        send_instr(mk_instr(OP_JAL,   X1, X0, X0, 32'h100, '0));
        send_instr(mk_instr(OP_ECALL, X0, X0, X0, '0, '0));
        send_instr(mk_instr(OP_UNUSED_LO, X1, X1, X1, '0, '0));
    endtask

    initial
    begin
        for (int i = 0; i < 16; i++)
            gpr[i] = '0;
        prog_ctr  = '0;
        load_pend = '0;
        halt_seen = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        src_idle_pct   = 10;
        sink_stall_pct = 10;
        test_reset_state();
        test_directed();
        test_random_traffic($urandom(),   550, 27, 83);
        test_random_traffic(32'h0,        550, 83, 27);
        test_random_traffic(32'hFFFF_FFFF, 450, 0, 0);
        test_backpressure();
        test_halt();

        settle_idle();
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("PASS rv32e_execute_unit");
        else
            $display("FAIL rv32e_execute_unit");
        $finish;
    end

endmodule
